[design/pls_pkg.sv]
// Package for the positional list store: sizes, codes, control struct and helpers.
`timescale 1ns / 1ps
`default_nettype none
package pls_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CMP_W      = (CNT_W > 6) ? CNT_W + 1 : 7;

  localparam logic [2:0] CMD_INS_FRONT = 3'd0;
  localparam logic [2:0] CMD_INS_BACK  = 3'd1;
  localparam logic [2:0] CMD_DEL_FRONT = 3'd2;
  localparam logic [2:0] CMD_DEL_BACK  = 3'd3;
  localparam logic [2:0] CMD_INS_AT    = 3'd4;
  localparam logic [2:0] CMD_DEL_AT    = 3'd5;
  localparam logic [2:0] CMD_DISPLAY   = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_ROT  = 2'd3;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    logic [1:0] op;
    idx_t       pos;
    idx_t       tail;
  } pls_ctrl_t;

  // low DATA_WIDTH bits of the input value, sign-extended if the cell is wider
  function automatic data_t to_cell(input logic [31:0] v);
    data_t r;
    int    s;
    for (int b = 0; b < DATA_WIDTH; b++) begin
      s    = (b < 32) ? b : 31;
      r[b] = v[s];
    end
    return r;
  endfunction

  // cell contents sign-extended or truncated to the 32-bit result field
  function automatic logic [31:0] to_item(input data_t d);
    logic [31:0] r;
    int          s;
    for (int b = 0; b < 32; b++) begin
      s    = (b < DATA_WIDTH) ? b : DATA_WIDTH - 1;
      r[b] = d[s];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[design/pls_cell.sv]
// One storage cell of the list chain: holds, shifts back, shifts forward or rotates.
`timescale 1ns / 1ps
`default_nettype none
module pls_cell (
  input  wire logic              clk,
  input  wire pls_pkg::pls_ctrl_t ctrl,
  input  wire pls_pkg::idx_t      idx,
  input  wire pls_pkg::data_t     left_data,
  input  wire pls_pkg::data_t     right_data,
  input  wire pls_pkg::data_t     head_data,
  input  wire pls_pkg::data_t     new_data,
  output pls_pkg::data_t          data
);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      pls_pkg::OP_INS: begin
        if (idx == ctrl.pos) data <= new_data;
        else if (idx > ctrl.pos) data <= left_data;
      end
      pls_pkg::OP_DEL: begin
        if (idx >= ctrl.pos) data <= right_data;
      end
      pls_pkg::OP_ROT: begin
        if (idx == ctrl.tail) data <= head_data;
        else if (idx < ctrl.tail) data <= right_data;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[design/pls_ctrl.sv]
// Command sequencer: fill count, position checks, display walk and result registers.
`timescale 1ns / 1ps
`default_nettype none
module pls_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [2:0]         cmd,
  input  wire logic [5:0]         position,
  input  wire pls_pkg::data_t     head_data,
  output logic                    busy,
  output pls_pkg::pls_ctrl_t      ctrl,
  output logic                    strobe,
  output logic [1:0]              status,
  output logic [4:0]              entry_count,
  output logic [31:0]             item_value,
  output logic                    item_valid,
  output logic                    last
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DISP = 1'b1;

  logic          state;
  logic          state_next;
  pls_pkg::cnt_t cnt;
  pls_pkg::cnt_t cnt_next;
  pls_pkg::idx_t disp_idx;
  logic          accept;
  logic          full;
  logic          empty;
  logic [pls_pkg::CMP_W-1:0] pos_w;
  logic [pls_pkg::CMP_W-1:0] cnt_w;
  logic          ins_ok;
  logic          del_ok;
  logic [1:0]    st;
  logic          emit;
  pls_pkg::idx_t tail;
  pls_pkg::idx_t pos_m1;
  logic [31:0]   cnt_out;

  assign busy   = (state == S_DISP);
  assign accept = start && !busy;
  assign full   = (cnt == pls_pkg::CNT_W'(pls_pkg::DEPTH));
  assign empty  = (cnt == '0);
  assign pos_w  = pls_pkg::CMP_W'(position);
  assign cnt_w  = pls_pkg::CMP_W'(cnt);
  assign ins_ok = (pos_w != '0) && (pos_w <= cnt_w + pls_pkg::CMP_W'(1));
  assign del_ok = (pos_w != '0) && (pos_w <= cnt_w);
  assign tail   = pls_pkg::IDX_W'(cnt - pls_pkg::CNT_W'(1));
  assign pos_m1 = pls_pkg::IDX_W'(position - 6'd1);

  always_comb begin
    ctrl.op    = pls_pkg::OP_HOLD;
    ctrl.pos   = '0;
    ctrl.tail  = tail;
    cnt_next   = cnt;
    st         = pls_pkg::ST_OK;
    emit       = 1'b0;
    state_next = state;
    if (busy) begin
      ctrl.op = pls_pkg::OP_ROT;
      if (disp_idx == tail) state_next = S_IDLE;
    end else if (accept) begin
      unique case (cmd)
        pls_pkg::CMD_INS_FRONT, pls_pkg::CMD_INS_BACK, pls_pkg::CMD_INS_AT: begin
          emit = 1'b1;
          if (full) begin
            st = pls_pkg::ST_FULL;
          end else if (cmd == pls_pkg::CMD_INS_AT && !ins_ok) begin
            st = pls_pkg::ST_BAD_POS;
          end else begin
            ctrl.op  = pls_pkg::OP_INS;
            cnt_next = cnt + pls_pkg::CNT_W'(1);
            if (cmd == pls_pkg::CMD_INS_BACK) ctrl.pos = pls_pkg::IDX_W'(cnt);
            else if (cmd == pls_pkg::CMD_INS_AT) ctrl.pos = pos_m1;
          end
        end
        pls_pkg::CMD_DEL_FRONT, pls_pkg::CMD_DEL_BACK, pls_pkg::CMD_DEL_AT: begin
          emit = 1'b1;
          if (empty) begin
            st = pls_pkg::ST_EMPTY;
          end else if (cmd == pls_pkg::CMD_DEL_AT && !del_ok) begin
            st = pls_pkg::ST_BAD_POS;
          end else begin
            ctrl.op  = pls_pkg::OP_DEL;
            cnt_next = cnt - pls_pkg::CNT_W'(1);
            if (cmd == pls_pkg::CMD_DEL_BACK) ctrl.pos = tail;
            else if (cmd == pls_pkg::CMD_DEL_AT) ctrl.pos = pos_m1;
          end
        end
        pls_pkg::CMD_DISPLAY: begin
          if (empty) emit = 1'b1;
          else state_next = S_DISP;
        end
        default: begin
        end
      endcase
    end
  end

  assign cnt_out = 32'(cnt_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      strobe   <= 1'b0;
      disp_idx <= '0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      strobe <= emit || busy;
      if (busy) disp_idx <= disp_idx + pls_pkg::IDX_W'(1);
      else disp_idx <= '0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    status      <= st;
    entry_count <= cnt_out[4:0];
    if (busy) begin
      item_value <= pls_pkg::to_item(head_data);
      item_valid <= 1'b1;
      last       <= (disp_idx == tail);
    end else begin
      item_value <= '0;
      item_valid <= 1'b0;
      last       <= 1'b1;
    end
  end

endmodule
`default_nettype wire

[design/positional_list_store_top.sv]
// Top level of the positional list store: sequencer and chain of storage cells.
// Edit commands: one transaction per cycle while not busy; result strobed in the cycle
// after acceptance. Display of n entries: busy while the entries are walked, one result
// per cycle, first after the state and result registers; next taken when busy falls.
// The cell chain rotates by one each display cycle and is back in order at the end.
// An empty display or edit gives one result with busy low; the receiver cannot stall.
// Synchronous reset empties the list at once; cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_store_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         cmd,
  input  wire logic signed [31:0] value,
  input  wire logic [5:0]         position,
  output logic                    strobe,
  output logic [1:0]              status,
  output logic [4:0]              entry_count,
  output logic signed [31:0]      item_value,
  output logic                    item_valid,
  output logic                    last
);

  pls_pkg::pls_ctrl_t ctrl;
  pls_pkg::data_t     cell_data [pls_pkg::DEPTH];
  pls_pkg::data_t     new_data;
  logic [31:0]        item_raw;

  assign new_data   = pls_pkg::to_cell(value);
  assign item_value = item_raw;

  pls_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .position    (position),
    .head_data   (cell_data[0]),
    .busy        (busy),
    .ctrl        (ctrl),
    .strobe      (strobe),
    .status      (status),
    .entry_count (entry_count),
    .item_value  (item_raw),
    .item_valid  (item_valid),
    .last        (last)
  );

  for (genvar g = 0; g < pls_pkg::DEPTH; g++) begin : g_cell
    pls_pkg::data_t left_d;
    pls_pkg::data_t right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == pls_pkg::DEPTH - 1) begin : g_end
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    pls_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (pls_pkg::IDX_W'(g)),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_data[0]),
      .new_data   (new_data),
      .data       (cell_data[g])
    );
  end

  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && item_valid |-> status == pls_pkg::ST_OK)
    else $error("display entry with non-ok status");

  a_busy_emits: assert property (@(posedge clk) disable iff (rst)
    busy |=> strobe && item_valid)
    else $error("display cycle without an entry");

  a_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && item_valid)
    else $error("display stopped before last mark");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> 32'(entry_count) <= pls_pkg::DEPTH)
    else $error("entry count above depth");

endmodule
`default_nettype wire

[verif/positional_list_store_top_test.sv]
// Testbench for the positional list store: directed and random commands, checked against a shadow list.
`timescale 1ns / 1ps
module positional_list_store_top_test;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic signed [31:0] item_value;
    logic               item_valid;
    logic               last;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [2:0]         cmd = pls_pkg::CMD_DISPLAY;
  logic signed [31:0] value = '0;
  logic [5:0]         position = '0;
  logic               busy;
  logic               strobe;
  logic [1:0]         status;
  logic [4:0]         entry_count;
  logic signed [31:0] item_value;
  logic               item_valid;
  logic               last;

  pls_pkg::data_t shadow_list[$];
  list_result_t   pending_results[$];
  int             mismatches = 0;
  int             burst_left = 0;

  positional_list_store_top DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .value       (value),
    .position    (position),
    .strobe      (strobe),
    .status      (status),
    .entry_count (entry_count),
    .item_value  (item_value),
    .item_valid  (item_valid),
    .last        (last)
  );

  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) $display("%0t MISMATCH: %s", $time, what);
    mismatches++;
  endtask

  function automatic void queue_result(input logic [1:0] st, input int count,
                                       input pls_pkg::data_t val, input logic valid,
                                       input logic fin);
    list_result_t r;
    r.status      = st;
    r.entry_count = count[4:0];
    r.item_value  = val;
    r.item_valid  = valid;
    r.last        = fin;
    pending_results.push_back(r);
  endfunction

  // applies one accepted command to the shadow list and queues what the block should answer
  function automatic void apply_list_command(input logic [2:0] c, input pls_pkg::data_t v,
                                             input logic [5:0] p);
    int         n;
    int         pos;
    logic [1:0] st;
    n   = shadow_list.size();
    pos = int'(p);
    st  = pls_pkg::ST_OK;
    case (c)
      pls_pkg::CMD_INS_FRONT, pls_pkg::CMD_INS_BACK, pls_pkg::CMD_INS_AT: begin
        if (n >= pls_pkg::DEPTH) st = pls_pkg::ST_FULL;
        else if (c == pls_pkg::CMD_INS_FRONT) shadow_list.push_front(v);
        else if (c == pls_pkg::CMD_INS_BACK) shadow_list.push_back(v);
        else if (pos < 1 || pos > n + 1) st = pls_pkg::ST_BAD_POS;
        else shadow_list.insert(pos - 1, v);
      end
      pls_pkg::CMD_DEL_FRONT, pls_pkg::CMD_DEL_BACK, pls_pkg::CMD_DEL_AT: begin
        if (n == 0) st = pls_pkg::ST_EMPTY;
        else if (c == pls_pkg::CMD_DEL_FRONT) void'(shadow_list.pop_front());
        else if (c == pls_pkg::CMD_DEL_BACK) void'(shadow_list.pop_back());
        else if (pos < 1 || pos > n) st = pls_pkg::ST_BAD_POS;
        else shadow_list.delete(pos - 1);
      end
      pls_pkg::CMD_DISPLAY: begin
        if (n == 0) queue_result(pls_pkg::ST_OK, 0, '0, 1'b0, 1'b1);
        for (int i = 0; i < n; i++)
          queue_result(pls_pkg::ST_OK, n, shadow_list[i], 1'b1, i == n - 1);
        return;
      end
      default: return;
    endcase
    queue_result(st, shadow_list.size(), '0, 1'b0, 1'b1);
  endfunction

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
        if (entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, wanted %0d", entry_count,
                                    want.entry_count));
        if (item_value !== want.item_value)
          report_mismatch($sformatf("item_value %0d, wanted %0d", item_value,
                                    want.item_value));
        if (item_valid !== want.item_valid)
          report_mismatch($sformatf("item_valid %0b, wanted %0b", item_valid,
                                    want.item_valid));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, wanted %0b", last, want.last));
      end
    end
  end

  // bursts of back-to-back transactions separated by random gaps, sometimes none
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_command(input logic [2:0] c, input logic signed [31:0] v,
                              input logic [5:0] p);
    start    <= 1'b1;
    cmd      <= c;
    value    <= v;
    position <= p;
    do @(posedge clk); while (busy);
    apply_list_command(c, v, p);
    pace_sender();
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_list();
    send_command(pls_pkg::CMD_DISPLAY, pick_value(), 6'd0);
    send_command(pls_pkg::CMD_DEL_FRONT, pick_value(), 6'd0);
    send_command(pls_pkg::CMD_DEL_AT, pick_value(), 6'd0);
    send_command(pls_pkg::CMD_INS_AT, pick_value(), 6'd0);
    send_command(CMD_UNUSED, pick_value(), 6'd1);
  endtask

  task automatic test_fill_to_capacity();
    logic [2:0] c;
    send_command(pls_pkg::CMD_INS_AT, 32'sh8000_0000, 6'd1);
    send_command(pls_pkg::CMD_INS_BACK, 32'sh7fff_ffff, 6'd63);
    send_command(pls_pkg::CMD_INS_FRONT, -32'sd1, 6'd0);
    while (shadow_list.size() < pls_pkg::DEPTH) begin
      case ($urandom_range(0, 2))
        0: c = pls_pkg::CMD_INS_FRONT;
        1: c = pls_pkg::CMD_INS_BACK;
        default: c = pls_pkg::CMD_INS_AT;
      endcase
      send_command(c, pick_value(), 6'($urandom_range(1, shadow_list.size() + 1)));
    end
    send_command(pls_pkg::CMD_INS_FRONT, pick_value(), 6'd1);
    send_command(pls_pkg::CMD_INS_AT, pick_value(), 6'd63);
    send_command(pls_pkg::CMD_DISPLAY, pick_value(), 6'd0);
  endtask

  task automatic test_position_limits();
    send_command(pls_pkg::CMD_DEL_AT, pick_value(), 6'd0);
    send_command(pls_pkg::CMD_DEL_AT, pick_value(), 6'd17);
    send_command(pls_pkg::CMD_DEL_AT, pick_value(), 6'd16);
    send_command(pls_pkg::CMD_INS_AT, pick_value(), 6'd17);
  endtask

  // phases lean towards growing, shrinking or neither so that full and empty are both visited
  task automatic test_random_traffic(input int count);
    int         sent;
    int         mode;
    int         phase_left;
    int         grow_pct;
    int         n;
    bit         is_insert;
    logic [2:0] c;
    logic [5:0] p;
    sent       = 0;
    phase_left = 0;
    mode       = 0;
    while (sent < count) begin
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 2);
        phase_left = $urandom_range(25, 60);
      end
      phase_left--;
      grow_pct  = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
      n         = shadow_list.size();
      is_insert = ($urandom_range(0, 99) < grow_pct);
      case ($urandom_range(0, 2))
        0: c = is_insert ? pls_pkg::CMD_INS_FRONT : pls_pkg::CMD_DEL_FRONT;
        1: c = is_insert ? pls_pkg::CMD_INS_BACK : pls_pkg::CMD_DEL_BACK;
        default: c = is_insert ? pls_pkg::CMD_INS_AT : pls_pkg::CMD_DEL_AT;
      endcase
      if ($urandom_range(0, 99) < 8) c = pls_pkg::CMD_DISPLAY;
      if ($urandom_range(0, 99) < 3) c = CMD_UNUSED;
      if ($urandom_range(0, 9) < 8)
        p = 6'($urandom_range(1, is_insert ? n + 1 : (n > 0 ? n : 1)));
      else
        p = 6'($urandom_range(0, 63));
      send_command(c, pick_value(), p);
      if (c != CMD_UNUSED) sent++;
    end
  endtask

  task automatic finish_run();
    int waited;
    start  <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (pls_pkg::DEPTH + 4) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_fill_to_capacity();
    test_position_limits();
    test_random_traffic(480);
    finish_run();
  end

endmodule
